@@ src/rkse_pkg.sv @@
`default_nettype none

package rkse_pkg;

  localparam int FUNC_W   = 2;
  localparam int RANK_W   = 10;
  localparam int POS_W    = 11;
  localparam int DOM_W    = 11;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FUNC_CLEAR  = 2'd0;
  localparam func_t FUNC_APPEND = 2'd1;
  localparam func_t FUNC_QUERY  = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_BAD  = 2'd1;
  localparam status_t ST_RANK = 2'd2;
  localparam status_t ST_FULL = 2'd3;

  localparam logic [DOM_W-1:0] DOM_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ src/rkse_if.sv @@
`default_nettype none

// Command channel: one clear, append or query per transfer.
interface rkse_req_if import rkse_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  rank_t value_rank;
  pos_t  range_first;
  pos_t  range_last;
  pos_t  kth;

  modport source (output valid, func, value_rank, range_first, range_last, kth,
                  input ready);
  modport sink   (input valid, func, value_rank, range_first, range_last, kth,
                  output ready);
endinterface

// Result channel: one result per command.
interface rkse_rsp_if import rkse_pkg::*; ();
  logic    valid;
  logic    ready;
  rank_t   result_rank;
  status_t status;

  modport source (output valid, result_rank, status, input ready);
  modport sink   (input valid, result_rank, status, output ready);
endinterface

`default_nettype wire

@@ src/range_kth_smallest_engine_unit.sv @@
// Persistent segment tree over value ranks with range k-th smallest queries.
// Commands arrive on the req channel (valid/ready); every command produces
// exactly one transfer on the rsp channel, in order. func selects clear,
// append or query. The cfg port writes the domain size; a write also empties
// the store. Configuration must be written only while no command is in
// flight; the block does not enforce this. An append walks S_CHECK, S_A_ROOT,
// S_A_WALK once per path node and S_RESP; a path has 1 + ceil(log2(domain))
// nodes (11 at the reset domain of 1024). A query walks S_CHECK, S_Q_ROOT,
// S_Q_NODE; a left step takes S_Q_LEFT, a right step S_Q_LEFT and S_Q_NODE.
// Clear and rejected commands go from S_CHECK to S_RESP. One command is worked
// on at a time; the next is accepted as soon as the previous result has been
// moved to the output register, even while that result waits for the receiver.
// If the receiver stalls, the finished result waits in the engine until the
// output register frees up. After reset the store is empty, the domain is
// 1024 ranks and node 0 serves as the shared empty tree; no memory is cleared.
`default_nettype none

module range_kth_smallest_engine_unit import rkse_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int RANK_BITS    = 10,
  parameter int NODE_POOL    = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [DOM_W-1:0] cfg_wdata,
  rkse_req_if.sink         req,
  rkse_rsp_if.source       rsp
);

  // Width plan. Node indices are NB bits; the free pointer can reach the pool
  // size, so it gets one more bit. Ranges lo/hi hold up to 2^RANK_BITS.
  localparam int NB   = $clog2(NODE_POOL);
  localparam int NFW  = NB + 1;
  localparam int PSW  = NB + 2;
  localparam int VA   = $clog2(MAX_ELEMENTS + 1);
  localparam int DW   = RANK_BITS + 1;
  localparam int CW   = (DW > POS_W) ? DW : POS_W;
  localparam int QW   = ((VA > POS_W) ? VA : POS_W) + 1;
  localparam int LVW  = $clog2(RANK_BITS + 2);
  localparam int NWW  = 2 * NB + CNT_W;
  localparam int TOP  = 2 ** RANK_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_A_ROOT = 3'd2;
  localparam logic [2:0] S_A_WALK = 3'd3;
  localparam logic [2:0] S_Q_ROOT = 3'd4;
  localparam logic [2:0] S_Q_NODE = 3'd5;
  localparam logic [2:0] S_Q_LEFT = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  // A domain of zero counts as one rank; anything above 2^RANK_BITS is cut.
  function automatic logic [DW-1:0] clamp_dom(input logic [DOM_W-1:0] v);
    logic [CW-1:0] wide;
    wide = CW'(v);
    if (v == '0) begin
      return DW'(1);
    end else if (wide > CW'(TOP)) begin
      return DW'(TOP);
    end else begin
      return DW'(v);
    end
  endfunction

  // Number of nodes on the longest root-to-leaf path.
  function automatic logic [LVW-1:0] levels_of(input logic [DW-1:0] d);
    logic [DW-1:0]  dm1;
    logic [LVW-1:0] lv;
    dm1 = d - DW'(1);
    lv  = LVW'(1);
    for (int i = 0; i < DW; i++) begin
      if (dm1[i]) begin
        lv = LVW'(i + 2);
      end
    end
    return lv;
  endfunction

  logic [2:0]          state;
  func_t               func_q;
  rank_t               rank_q;
  pos_t                first_q;
  pos_t                last_q;
  pos_t                k_q;
  logic [VA-1:0]       vu;
  logic [NFW-1:0]      nf;
  logic [DW-1:0]       dom_eff;
  logic [LVW-1:0]      path_lv;
  logic [DW-1:0]       lo;
  logic [DW-1:0]       hi;
  logic [NB-1:0]       ru_q;
  logic [NB-1:0]       rv_q;
  logic                nul_a;
  logic                nul_b;
  logic                vnul_a;
  logic                vnul_b;
  rank_t               res_rank;
  status_t             res_status;
  logic                out_valid;
  rank_t               out_rank;
  status_t             out_status;

  // Memory ports.
  logic                nd_we;
  logic [NB-1:0]       nd_waddr;
  logic [NWW-1:0]      nd_wdata;
  logic [NB-1:0]       nd_ra;
  logic [NB-1:0]       nd_rb;
  logic [NWW-1:0]      nd_qa;
  logic [NWW-1:0]      nd_qb;
  logic                vr_we;
  logic [VA-1:0]       vr_waddr;
  logic [NB-1:0]       vr_wdata;
  logic [VA-1:0]       vr_ra;
  logic [VA-1:0]       vr_rb;
  logic [NB-1:0]       vr_qa;
  logic [NB-1:0]       vr_qb;

  rkse_ram #(.WIDTH(NWW), .DEPTH(NODE_POOL)) u_node_ram (
    .clk     (clk),
    .we      (nd_we),
    .waddr   (nd_waddr),
    .wdata   (nd_wdata),
    .raddr_a (nd_ra),
    .rdata_a (nd_qa),
    .raddr_b (nd_rb),
    .rdata_b (nd_qb)
  );

  rkse_ram #(.WIDTH(NB), .DEPTH(MAX_ELEMENTS + 1)) u_root_ram (
    .clk     (clk),
    .we      (vr_we),
    .waddr   (vr_waddr),
    .wdata   (vr_wdata),
    .raddr_a (vr_ra),
    .rdata_a (vr_qa),
    .raddr_b (vr_rb),
    .rdata_b (vr_qb)
  );

  // Node 0 and version 0 are never written. Reads of index 0 are replaced by
  // the empty node (self-linked, count zero), so no reset pass is needed.
  logic [NWW-1:0] na;
  logic [NWW-1:0] nb;
  logic [NB-1:0]  va;
  logic [NB-1:0]  vb;
  logic [NB-1:0]  na_left;
  logic [NB-1:0]  na_right;
  logic [CNT_W-1:0] na_cnt;
  logic [NB-1:0]  nb_left;
  logic [NB-1:0]  nb_right;
  logic [CNT_W-1:0] nb_cnt;

  assign na       = nul_a ? '0 : nd_qa;
  assign nb       = nul_b ? '0 : nd_qb;
  assign va       = vnul_a ? '0 : vr_qa;
  assign vb       = vnul_b ? '0 : vr_qb;
  assign na_left  = na[NWW-1 -: NB];
  assign na_right = na[CNT_W +: NB];
  assign na_cnt   = na[CNT_W-1:0];
  assign nb_left  = nb[NWW-1 -: NB];
  assign nb_right = nb[CNT_W +: NB];
  assign nb_cnt   = nb[CNT_W-1:0];

  // Range split shared by the append and query walks.
  logic [DW:0]   span_sum;
  logic [DW-1:0] mid;
  logic          leaf;
  logic          leaf_left;

  assign span_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid       = span_sum[DW:1];
  assign leaf      = (hi - lo) <= DW'(1);
  assign leaf_left = (mid - lo) <= DW'(1);

  // Append admission checks; the rank check has priority over the full checks.
  logic           rank_bad;
  logic           vers_full;
  logic           pool_full;
  logic           app_ok;
  logic           a_left;
  logic [NB-1:0]  nf_child;

  assign rank_bad  = CW'(rank_q) >= CW'(dom_eff);
  assign vers_full = vu >= VA'(MAX_ELEMENTS);
  assign pool_full = (PSW'(nf) + PSW'(path_lv)) > PSW'(NODE_POOL);
  assign app_ok    = !rank_bad && !vers_full && !pool_full;
  assign a_left    = CW'(rank_q) < CW'(mid);
  assign nf_child  = NB'(nf + NFW'(1));

  // Query admission: 1 <= first <= last <= versions, 1 <= k <= last-first+1.
  logic [QW-1:0] qf;
  logic [QW-1:0] ql;
  logic [QW-1:0] qk;
  logic          q_bad;

  assign qf    = QW'(first_q);
  assign ql    = QW'(last_q);
  assign qk    = QW'(k_q);
  assign q_bad = (qf == '0) || (qf > ql) || (ql > QW'(vu)) || (qk == '0) ||
                 (qk > (ql - qf + QW'(1)));

  // Count in the left subtree of the range. A negative difference (only
  // possible once counts wrap) compares as huge, so the walk goes left.
  logic [CNT_W:0] q_diff;
  logic           q_take_left;

  assign q_diff      = {1'b0, nb_cnt} - {1'b0, na_cnt};
  assign q_take_left = q_diff[CNT_W] || (k_q <= POS_W'(q_diff[CNT_W-1:0]));

  // Memory addressing. Writes only target freshly allocated nodes, which are
  // always above every node a walk can read, so reads and writes never meet
  // on the same entry and no forwarding is needed.
  always_comb begin
    nd_we    = 1'b0;
    nd_waddr = nf[NB-1:0];
    nd_wdata = {(!leaf && a_left)  ? nf_child : na_left,
                (!leaf && !a_left) ? nf_child : na_right,
                na_cnt + CNT_W'(1)};
    nd_ra    = '0;
    nd_rb    = '0;
    vr_we    = 1'b0;
    vr_waddr = vu + VA'(1);
    vr_wdata = nf[NB-1:0];
    vr_ra    = '0;
    vr_rb    = '0;
    case (state)
      S_CHECK: begin
        if (func_q == FUNC_APPEND && app_ok) begin
          vr_ra = vu;
          vr_we = 1'b1;
        end else if (func_q == FUNC_QUERY && !q_bad) begin
          vr_ra = VA'(qf - QW'(1));
          vr_rb = VA'(last_q);
        end
      end
      S_A_ROOT: begin
        nd_ra = va;
      end
      S_A_WALK: begin
        nd_we = 1'b1;
        if (!leaf) begin
          nd_ra = a_left ? na_left : na_right;
        end
      end
      S_Q_ROOT: begin
        nd_ra = va;
        nd_rb = vb;
      end
      S_Q_NODE: begin
        nd_ra = na_left;
        nd_rb = nb_left;
      end
      S_Q_LEFT: begin
        if (q_take_left) begin
          nd_ra = na_left;
          nd_rb = nb_left;
        end else begin
          nd_ra = ru_q;
          nd_rb = rv_q;
        end
      end
      default: begin
      end
    endcase
  end

  // The RAMs read every cycle, so the empty-node flags follow the addresses.
  always_ff @(posedge clk) begin
    nul_a  <= (nd_ra == '0);
    nul_b  <= (nd_rb == '0);
    vnul_a <= (vr_ra == '0);
    vnul_b <= (vr_rb == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      vu        <= '0;
      nf        <= NFW'(1);
      dom_eff   <= clamp_dom(DOM_RESET);
      path_lv   <= levels_of(clamp_dom(DOM_RESET));
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      // A new domain changes the tree shape, so the store is emptied.
      if (cfg_we) begin
        dom_eff <= clamp_dom(cfg_wdata);
        path_lv <= levels_of(clamp_dom(cfg_wdata));
        vu      <= '0;
        nf      <= NFW'(1);
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            func_q  <= req.func;
            rank_q  <= req.value_rank;
            first_q <= req.range_first;
            last_q  <= req.range_last;
            k_q     <= req.kth;
            state   <= S_CHECK;
          end
        end

        S_CHECK: begin
          res_rank <= '0;
          lo       <= '0;
          hi       <= dom_eff;
          case (func_q)
            FUNC_CLEAR: begin
              vu         <= '0;
              nf         <= NFW'(1);
              res_status <= ST_OK;
              state      <= S_RESP;
            end
            FUNC_APPEND: begin
              if (rank_bad) begin
                res_status <= ST_RANK;
                state      <= S_RESP;
              end else if (!app_ok) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                state <= S_A_ROOT;
              end
            end
            FUNC_QUERY: begin
              if (q_bad) begin
                res_status <= ST_BAD;
                state      <= S_RESP;
              end else begin
                state <= S_Q_ROOT;
              end
            end
            default: begin
              res_status <= ST_BAD;
              state      <= S_RESP;
            end
          endcase
        end

        S_A_ROOT: begin
          state <= S_A_WALK;
        end

        // One node per cycle: copy the source node, bump its count, and point
        // the child on the path at the node allocated next.
        S_A_WALK: begin
          nf <= nf + NFW'(1);
          if (leaf) begin
            vu         <= vu + VA'(1);
            res_status <= ST_OK;
            state      <= S_RESP;
          end else if (a_left) begin
            hi <= mid;
          end else begin
            lo <= mid;
          end
        end

        S_Q_ROOT: begin
          state <= S_Q_NODE;
        end

        S_Q_NODE: begin
          if (leaf) begin
            res_rank   <= RANK_W'(lo[RANK_BITS-1:0]);
            res_status <= ST_OK;
            state      <= S_RESP;
          end else begin
            ru_q  <= na_right;
            rv_q  <= nb_right;
            state <= S_Q_LEFT;
          end
        end

        // The RAM outputs hold the left children of the current pair.
        S_Q_LEFT: begin
          if (q_take_left) begin
            hi <= mid;
            if (leaf_left) begin
              res_rank   <= RANK_W'(lo[RANK_BITS-1:0]);
              res_status <= ST_OK;
              state      <= S_RESP;
            end else begin
              ru_q <= na_right;
              rv_q <= nb_right;
            end
          end else begin
            k_q   <= k_q - POS_W'(q_diff[CNT_W-1:0]);
            lo    <= mid;
            state <= S_Q_NODE;
          end
        end

        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_rank   <= res_rank;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.result_rank = out_rank;
  assign rsp.status      = out_status;

endmodule

`default_nettype wire

@@ src/rkse_ram.sv @@
`default_nettype none

// Simple dual-read RAM: one write port, two read ports, registered read data.
module rkse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                       rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ src/rkse_checker.sv @@
`default_nettype none

module rkse_checker import rkse_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    req_valid,
  input wire logic    req_ready,
  input wire logic    rsp_valid,
  input wire logic    rsp_ready,
  input wire rank_t   rsp_result_rank,
  input wire status_t rsp_status
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend;

  assign in_xfer  = req_valid && req_ready;
  assign out_xfer = rsp_valid && rsp_ready;

  // Commands accepted but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else begin
      pend <= pend + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !req_ready)
    else $error("command accepted while the previous one is still in work");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> pend != 2'd0)
    else $error("result transfer without an outstanding command");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> pend <= 2'd1)
    else $error("more than one finished result left undelivered");

  a_error_rank_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_result_rank == '0)
    else $error("rejected command returned a nonzero rank");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_result_rank) && $stable(rsp_status))
    else $error("stalled result changed");

endmodule

bind range_kth_smallest_engine_unit rkse_checker u_rkse_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_result_rank (rsp.result_rank),
  .rsp_status      (rsp.status)
);

`default_nettype wire

@@ tb/sv/tb_range_kth_smallest_engine_unit.sv @@
module tb_range_kth_smallest_engine_unit;
  import rkse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Sizes of the instance under test (its default parameters).
  localparam int MAX_VERS = 1024;
  localparam int NODES    = 16384;

  // The one func code the package leaves unnamed; the block must reject it.
  localparam func_t FUNC_UNUSED = 2'd3;

  // Cycles the receiver refuses results during the back-pressure test.
  localparam int HOLD_CYCLES = 300;

  // Cycles allowed after the last expected result, for anything stray.
  localparam int TAIL_CYCLES = 60;

  typedef logic [13:0] node_t;

  typedef struct packed {
    func_t func;
    rank_t value_rank;
    pos_t  range_first;
    pos_t  range_last;
    pos_t  kth;
  } cmd_t;

  typedef struct packed {
    rank_t   rank;
    status_t status;
  } answer_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [DOM_W-1:0] cfg_wdata;

  rkse_req_if req_ch ();
  rkse_rsp_if rsp_ch ();

  range_kth_smallest_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the persistent tree. Every append copies one node per
  // level, so the node arrays only ever grow until a clear or a domain write.
  // ---------------------------------------------------------------------------
  bit [13:0]      kid_left  [NODES];
  bit [13:0]      kid_right [NODES];
  bit [CNT_W-1:0] hits      [NODES];
  bit [13:0]      ver_root  [MAX_VERS + 1];
  int unsigned    pool_next = 1;
  int unsigned    ver_count = 0;
  bit [DOM_W-1:0] dom_cfg   = DOM_RESET;

  // Results the block still owes us, oldest first.
  answer_t answers_due [$];

  // Knobs for the traffic shape.
  bit src_gaps      = 1'b1;
  bit sink_stalls   = 1'b1;
  bit hold_off_req  = 1'b0;

  int errors      = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_appends   = 0;
  int n_queries   = 0;
  int n_found     = 0;
  int n_full      = 0;
  int n_domains   = 0;
  int most_vers   = 0;

  // The register is clamped to 1 .. 2^RANK_W ranks.
  function automatic int unsigned eff_domain();
    if (dom_cfg == 0) return 1;
    if (dom_cfg > (1 << RANK_W)) return 1 << RANK_W;
    return dom_cfg;
  endfunction

  // Nodes on the longest root-to-leaf path for a domain of d ranks.
  function automatic int unsigned path_nodes(int unsigned d);
    int unsigned lv;
    int unsigned span;
    lv = 1;
    span = 1;
    while (span < d) begin
      span = span << 1;
      lv++;
    end
    return lv;
  endfunction

  // Node 0 stays the shared empty tree: it links to itself and counts zero.
  function automatic void empty_store();
    kid_left[0]  = '0;
    kid_right[0] = '0;
    hits[0]      = '0;
    ver_root[0]  = '0;
    pool_next    = 1;
    ver_count    = 0;
  endfunction

  function automatic status_t insert_rank(int unsigned rank);
    int unsigned d, lo, hi, mid, src, dst, parent;
    bit went_left, at_root;
    d = eff_domain();
    lo = 0;
    hi = d;
    parent = 0;
    went_left = 1'b0;
    at_root = 1'b1;
    if (rank >= d) return ST_RANK;
    if (ver_count >= MAX_VERS) return ST_FULL;
    if (pool_next + path_nodes(d) > NODES) return ST_FULL;
    src = ver_root[ver_count];
    while (1) begin
      dst = pool_next;
      pool_next++;
      kid_left[dst]  = kid_left[src];
      kid_right[dst] = kid_right[src];
      hits[dst]      = hits[src] + 1'b1;
      if (at_root) begin
        ver_root[ver_count + 1] = dst;
        at_root = 1'b0;
      end else if (went_left) begin
        kid_left[parent] = dst;
      end else begin
        kid_right[parent] = dst;
      end
      if (hi - lo <= 1) break;
      mid = (lo + hi) >> 1;
      parent = dst;
      if (rank < mid) begin
        went_left = 1'b1;
        src = kid_left[src];
        hi = mid;
      end else begin
        went_left = 1'b0;
        src = kid_right[src];
        lo = mid;
      end
    end
    ver_count++;
    return ST_OK;
  endfunction

  // Walk versions first-1 and last side by side; the count difference of the
  // left children says which half holds the k-th smallest.
  function automatic status_t find_kth(int unsigned first_pos, int unsigned last_pos,
                                       int unsigned k, output rank_t rank);
    node_t u, v, lu, lv;
    int unsigned lo, hi, mid, left_n;
    rank = '0;
    lo = 0;
    hi = eff_domain();
    if (first_pos < 1 || first_pos > last_pos || last_pos > ver_count) return ST_BAD;
    if (k < 1 || k > last_pos - first_pos + 1) return ST_BAD;
    u = ver_root[first_pos - 1];
    v = ver_root[last_pos];
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      lv = kid_left[v];
      lu = kid_left[u];
      left_n = hits[lv] - hits[lu];
      if (k <= left_n) begin
        u = lu;
        v = lv;
        hi = mid;
      end else begin
        k = k - left_n;
        u = kid_right[u];
        v = kid_right[v];
        lo = mid;
      end
    end
    rank = lo[RANK_W-1:0];
    return ST_OK;
  endfunction

  function automatic answer_t predict_answer(cmd_t c);
    answer_t a;
    rank_t found;
    a.rank = '0;
    case (c.func)
      FUNC_CLEAR: begin
        empty_store();
        a.status = ST_OK;
      end
      FUNC_APPEND: a.status = insert_rank(c.value_rank);
      FUNC_QUERY: begin
        a.status = find_kth(c.range_first, c.range_last, c.kth, found);
        a.rank = found;
      end
      default: a.status = ST_BAD;
    endcase
    return a;
  endfunction

  function automatic cmd_t mk_cmd(func_t f, int unsigned r, int unsigned a,
                                  int unsigned b, int unsigned k);
    cmd_t c;
    c.func        = f;
    c.value_rank  = rank_t'(r);
    c.range_first = pos_t'(a);
    c.range_last  = pos_t'(b);
    c.kth         = pos_t'(k);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. valid is left high after a transfer so that back-to-back
  // commands need no dead cycle; whoever pauses the stream lowers it in the
  // same time step as the last transfer (see finish_outstanding).
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input cmd_t c);
    answer_t a;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= c.func;
    req_ch.value_rank  <= c.value_rank;
    req_ch.range_first <= c.range_first;
    req_ch.range_last  <= c.range_last;
    req_ch.kth         <= c.kth;
    do begin
      @(posedge clk);
    end while (req_ch.ready !== 1'b1);
    // The transfer happened at this edge, so the shadow tree moves now.
    a = predict_answer(c);
    answers_due.push_back(a);
    n_sent++;
    if (c.func == FUNC_APPEND) n_appends++;
    if (c.func == FUNC_QUERY) n_queries++;
    if (c.func == FUNC_QUERY && a.status == ST_OK) n_found++;
    if (a.status == ST_FULL) n_full++;
    if (ver_count > most_vers) most_vers = ver_count;
  endtask

  // Stop offering commands and wait for every owed result. Since every command
  // yields exactly one result, the block is idle once the queue is empty.
  task automatic finish_outstanding();
    req_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // A domain write also empties the store, in the block and in the shadow.
  task automatic set_domain(input logic [DOM_W-1:0] d);
    finish_outstanding();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    dom_cfg = d;
    empty_store();
    n_domains++;
  endtask

  // One random command. Most are well formed so that the tree grows deep and
  // queries span many versions; the rest are out-of-domain appends, near-miss
  // queries, pure noise and the unused func code.
  task automatic send_random(input int unsigned append_pct, input bit allow_clear);
    cmd_t c;
    int unsigned roll, n, d, len;
    d = eff_domain();
    n = ver_count;
    c.func        = FUNC_QUERY;
    c.value_rank  = rank_t'($urandom_range(0, 1023));
    c.range_first = pos_t'($urandom_range(0, 2047));
    c.range_last  = pos_t'($urandom_range(0, 2047));
    c.kth         = pos_t'($urandom_range(0, 2047));
    roll = $urandom_range(0, 99);
    if (allow_clear && roll < 2) begin
      c.func = FUNC_CLEAR;
    end else if (roll < append_pct) begin
      c.func = FUNC_APPEND;
      // Lean on the two ends of the domain now and then.
      case ($urandom_range(0, 5))
        0: c.value_rank = '0;
        1: c.value_rank = rank_t'(d - 1);
        default: c.value_rank = rank_t'($urandom_range(0, d - 1));
      endcase
    end else if (roll < append_pct + 4) begin
      // Rank drawn over the whole field, so often outside a small domain.
      c.func = FUNC_APPEND;
    end else if (roll < 97 && n > 0) begin
      c.range_first = pos_t'($urandom_range(1, n));
      c.range_last  = pos_t'($urandom_range(c.range_first, n));
      if ($urandom_range(0, 7) == 0) begin
        c.range_first = 1;
        c.range_last  = n;
      end
      len = c.range_last - c.range_first + 1;
      c.kth = pos_t'($urandom_range(1, len));
      if ($urandom_range(0, 5) == 0) c.kth = (len > 1 && $urandom_range(0, 1)) ? len : 1;
      // A few queries miss by exactly one on some bound.
      if (roll >= 93) begin
        case ($urandom_range(0, 4))
          0: c.range_first = 0;
          1: c.range_first = c.range_last + 1;
          2: c.range_last  = n + 1;
          3: c.kth = 0;
          default: c.kth = len + 1;
        endcase
      end
    end else if (roll == 99) begin
      c.func = FUNC_UNUSED;
    end
    send_cmd(c);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls in short random bursts, and once in the
  // run refuses results for a long stretch when asked to.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is matched against the oldest owed answer.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result transfer: result_rank %0d, status %0d",
               rsp_ch.result_rank, rsp_ch.status);
        errors++;
      end else begin
        want = answers_due.pop_front();
        n_checked++;
        if (rsp_ch.result_rank !== want.rank) begin
          $error("result_rank: expected %0d, actual %0d", want.rank, rsp_ch.result_rank);
          errors++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked commands at the reset domain of 1024 ranks: the edges of every
  // field, each way a query can be malformed, the unused func code and clear.
  task automatic test_directed_cases();
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 1, 1));          // nothing stored yet
    send_cmd(mk_cmd(FUNC_UNUSED, 1023, 2047, 2047, 2047));
    send_cmd(mk_cmd(FUNC_APPEND, 0, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_APPEND, 1023, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_APPEND, 512, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 3, 1));          // minimum
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 3, 3));          // maximum
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 3, 2));
    send_cmd(mk_cmd(FUNC_QUERY, 0, 2, 3, 1));          // range not starting at 1
    send_cmd(mk_cmd(FUNC_QUERY, 0, 0, 3, 1));          // first position zero
    send_cmd(mk_cmd(FUNC_QUERY, 0, 3, 2, 1));          // first after last
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 4, 1));          // last beyond the store
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 3, 0));          // k of zero
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 3, 4));          // k longer than the range
    send_cmd(mk_cmd(FUNC_QUERY, 1023, 2047, 2047, 2047));
    send_cmd(mk_cmd(FUNC_CLEAR, 0, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 1, 1));          // store is empty again
    send_cmd(mk_cmd(FUNC_APPEND, 1023, 0, 0, 0));
  endtask

  // Out-of-range register values are clamped, and each write empties the store.
  task automatic test_domain_clamping();
    set_domain(0);                                     // behaves as one rank
    send_cmd(mk_cmd(FUNC_APPEND, 0, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_APPEND, 1, 0, 0, 0));         // outside the domain
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 1, 1));
    set_domain(11'h7FF);                               // behaves as 1024 ranks
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 1, 1));          // wiped by the write
    send_cmd(mk_cmd(FUNC_APPEND, 1023, 0, 0, 0));
    set_domain(3);
    send_cmd(mk_cmd(FUNC_APPEND, 3, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_APPEND, 2, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, 1, 1));
  endtask

  // Random mixes over a spread of tree shapes, from a single leaf up to the
  // full 1024 ranks, including odd sizes whose halves are uneven.
  task automatic test_random_domains();
    logic [DOM_W-1:0] sizes [7];
    sizes = '{11'd1024, 11'd1, 11'd2, 11'd1025, 11'd700, 11'd37, 11'd513};
    foreach (sizes[i]) begin
      set_domain(sizes[i]);
      repeat (45) send_random(45, 1'b1);
    end
  endtask

  // Fill every version slot, keep asking questions over the whole history,
  // then confirm that appends are refused and that a bad rank still wins.
  task automatic test_store_full();
    set_domain(5);
    while (ver_count < MAX_VERS) send_random(85, 1'b0);
    repeat (20) send_random(50, 1'b0);
    send_cmd(mk_cmd(FUNC_APPEND, 7, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, MAX_VERS, MAX_VERS));
    send_cmd(mk_cmd(FUNC_QUERY, 0, 1, MAX_VERS, 1));
    send_cmd(mk_cmd(FUNC_CLEAR, 0, 0, 0, 0));
    send_cmd(mk_cmd(FUNC_APPEND, 4, 0, 0, 0));         // room again after clear
  endtask

  // The receiver refuses results for a long stretch while commands keep
  // coming, so the result register and the engine fill and the block must
  // hold off its command input without losing anything.
  task automatic test_receiver_hold();
    set_domain(1024);
    hold_off_req = 1'b1;
    repeat (40) send_random(55, 1'b0);
  endtask

  // Last stretch: no idling on either side, so commands and results move on
  // every cycle the block allows.
  task automatic test_steady_stream();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    set_domain(1024);
    repeat (110) send_random(50, 1'b1);
  endtask

  initial begin : run_tests
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.func        <= FUNC_CLEAR;
    req_ch.value_rank  <= '0;
    req_ch.range_first <= '0;
    req_ch.range_last  <= '0;
    req_ch.kth         <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_domain_clamping();
    test_random_domains();
    test_store_full();
    test_receiver_hold();
    test_steady_stream();

    finish_outstanding();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (answers_due.size() != 0) begin
      $error("%0d results never arrived", answers_due.size());
      errors++;
    end

    $display("Ran %0d commands (%0d appends, %0d queries, %0d of them answered) over %0d domain writes.",
             n_sent, n_appends, n_queries, n_found, n_domains);
    $display("Checked %0d results; history reached %0d versions, %0d appends refused as full.",
             n_checked, most_vers, n_full);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Far beyond the slowest legal run (roughly 0.7 ms with every gap and stall).
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results outstanding.", answers_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
src/rkse_pkg.sv
src/rkse_if.sv
src/rkse_ram.sv
src/range_kth_smallest_engine_unit.sv
src/rkse_checker.sv
tb/sv/tb_range_kth_smallest_engine_unit.sv
